FILE: src/generational_handle_table_macros.svh
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define GHT_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ght: assertion failed");
`define GHT_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ght: assertion failed");
`else
`define GHT_ASSERT_IMP(name, clk, rstn, ante, cons)
`define GHT_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types, codes and constants shared by the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int TableEntriesDef = 64;
  localparam int RefBitsDef      = 32;

  localparam int IdxBits  = 8;   // handle index field
  localparam int DomBits  = 8;
  localparam int GenBits  = 16;
  localparam int WordBits = 32;  // handle and reference port fields
  localparam int CntBits  = 7;   // reported active count
  localparam int GrpSize  = 16;  // free-slot finder group
  localparam int GrpBits  = 4;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_LOOKUP   = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_INIT     = 3'd3,
    CMD_SHUTDOWN = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_NOT_INIT   = 3'd2,
    ST_BAD_ARG    = 3'd3,
    ST_FULL       = 3'd4,
    ST_BAD_HANDLE = 3'd5,
    ST_EXPIRED    = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [WordBits-1:0] allocation_ref;
    logic [DomBits-1:0]  domain;
    logic [WordBits-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [WordBits-1:0] handle_out;
    logic [WordBits-1:0] allocation_out;
    logic [GenBits-1:0]  generation_out;
    logic [CntBits-1:0]  used_slots;
  } out_t;

endpackage

`default_nettype wire

FILE: src/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/ght_free_find.sv
// ----------------------------------------------------------------------------
// ght_free_find
// Lowest-free-slot finder: registered per-group encode, then group select.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_free_find #(
  parameter int TABLE_ENTRIES = ght_pkg::TableEntriesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [TABLE_ENTRIES-1:0]    in_use_i,
  output logic                             found_o,
  output logic [ght_pkg::IdxBits-1:0]      slot_o
);

  localparam int Grp    = ght_pkg::GrpSize;
  localparam int NumGrp = (TABLE_ENTRIES + Grp - 1) / Grp;
  localparam int PadLen = NumGrp * Grp;
  localparam int GrpW   = (NumGrp > 1) ? $clog2(NumGrp) : 1;

  logic [PadLen-1:0]             used_pad;
  logic [NumGrp-1:0]             grp_free_d, grp_free_q;
  logic [ght_pkg::GrpBits-1:0]   grp_low_d [NumGrp];
  logic [ght_pkg::GrpBits-1:0]   grp_low_q [NumGrp];
  logic [GrpW-1:0]               grp_sel;

  // entries past the table count as used
  for (genvar i = 0; i < PadLen; i++) begin : g_pad
    if (i < TABLE_ENTRIES) begin : g_real
      assign used_pad[i] = in_use_i[i];
    end else begin : g_fill
      assign used_pad[i] = 1'b1;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_free_d[g] = ~&used_pad[g*Grp +: Grp];
      grp_low_d[g]  = '0;
      for (int j = Grp - 1; j >= 0; j--) begin
        if (!used_pad[g*Grp + j]) begin
          grp_low_d[g] = ght_pkg::GrpBits'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_free_q <= '0;
    end else if (load_i) begin
      grp_free_q <= grp_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_low_q <= grp_low_d;
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        grp_sel = GrpW'(g);
      end
    end
  end

  assign found_o = |grp_free_q;
  assign slot_o  = ght_pkg::IdxBits'({grp_sel, grp_low_q[grp_sel]});

endmodule

`default_nettype wire

FILE: src/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot table of generation-stamped allocation references addressed by handle.
// ----------------------------------------------------------------------------
// Timing: the command and the RAM read are registered with the input transfer;
//   the read-modify-write and the load of the output register follow in the
//   execute state, which is held while the output register is still held.
// Throughput: a new command is taken only after the previous one has executed.
// Reset: not initialized, all slots free, generation 1, count 0. The slot RAM
//   is not cleared; entries are read only behind a set in-use bit.
`default_nettype none

`include "generational_handle_table_macros.svh"

module generational_handle_table #(
  parameter int TABLE_ENTRIES = ght_pkg::TableEntriesDef,
  parameter int REF_BITS      = ght_pkg::RefBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ght_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ght_pkg::out_t      out_data_o
);

  localparam int AddrW = $clog2(TABLE_ENTRIES);
  localparam int CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int GenW  = ght_pkg::GenBits;
  localparam int RamW  = GenW + REF_BITS;

  ght_pkg::state_e state_q, state_d;
  ght_pkg::in_t    cmd_q;
  ght_pkg::out_t   out_q, res;

  logic                     out_valid_q, out_valid_d;
  logic                     init_q, init_d;
  logic [TABLE_ENTRIES-1:0] in_use_q, in_use_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [GenW-1:0]          gen_q, gen_d;

  logic                     accept, fire, ram_re;
  logic                     ram_we;
  logic [RamW-1:0]          ram_rdata;
  logic                     free_found;
  logic [ght_pkg::IdxBits-1:0] free_slot;

  logic [REF_BITS-1:0]      aref, rd_ref;
  logic [GenW-1:0]          rd_gen, hgen;
  logic [ght_pkg::IdxBits-1:0] idx;
  logic                     idx_ok, slot_used;

  assign accept = in_valid_i && in_ready_o;
  assign fire   = (state_q == ght_pkg::S_EXEC) && (!out_valid_q || out_ready_i);

  // ---------------- FSM ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ght_pkg::S_IDLE: if (in_valid_i) state_d = ght_pkg::S_EXEC;
      ght_pkg::S_EXEC: if (fire) state_d = ght_pkg::S_IDLE;
      default:         state_d = ght_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    unique case (state_q)
      ght_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      ght_pkg::S_EXEC: begin
        in_ready_o = 1'b0;
        ram_re     = 1'b0;
      end
      default: begin
        in_ready_o = 1'b0;
        ram_re     = 1'b0;
      end
    endcase
  end

  // ---------------- storage ----------------
  ght_ram #(
    .WIDTH (RamW),
    .DEPTH (TABLE_ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot[AddrW-1:0]),
    .wdata_i ({gen_q, aref}),
    .re_i    (ram_re),
    .raddr_i (in_data_i.handle[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  ght_free_find #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_free_find (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .in_use_i (in_use_q),
    .found_o  (free_found),
    .slot_o   (free_slot)
  );

  // ---------------- execute ----------------
  assign aref      = REF_BITS'(cmd_q.allocation_ref);
  assign rd_gen    = ram_rdata[RamW-1 -: GenW];
  assign rd_ref    = ram_rdata[REF_BITS-1:0];
  assign idx       = cmd_q.handle[ght_pkg::IdxBits-1:0];
  assign hgen      = cmd_q.handle[ght_pkg::WordBits-1 -: GenW];
  assign idx_ok    = {1'b0, idx} < (ght_pkg::IdxBits + 1)'(TABLE_ENTRIES);
  assign slot_used = in_use_q[idx[AddrW-1:0]];

  always_comb begin
    init_d   = init_q;
    in_use_d = in_use_q;
    count_d  = count_q;
    gen_d    = gen_q;
    ram_we   = 1'b0;
    res      = '0;
    res.status = ght_pkg::ST_OK;

    unique case (cmd_q.cmd)
      ght_pkg::CMD_INSERT: begin
        if (aref == '0) begin
          res.status = ght_pkg::ST_BAD_ARG;
        end else if (!init_q) begin
          res.status = ght_pkg::ST_NOT_INIT;
        end else if (!free_found) begin
          res.status = ght_pkg::ST_FULL;
        end else begin
          ram_we = fire;
          in_use_d[free_slot[AddrW-1:0]] = 1'b1;
          count_d = count_q + 1'b1;
          gen_d   = (gen_q == '1) ? GenW'(1) : gen_q + 1'b1;
          res.handle_out     = {gen_q, cmd_q.domain, free_slot};
          res.generation_out = gen_q;
        end
      end
      ght_pkg::CMD_LOOKUP: begin
        if (cmd_q.handle == '0) begin
          res.status = ght_pkg::ST_BAD_ARG;
        end else if (!init_q) begin
          res.status = ght_pkg::ST_NOT_INIT;
        end else if (!idx_ok) begin
          res.status = ght_pkg::ST_BAD_HANDLE;
        end else if (!slot_used || rd_gen != hgen || rd_ref == '0) begin
          res.status = ght_pkg::ST_EXPIRED;
        end else begin
          res.allocation_out = ght_pkg::WordBits'(rd_ref);
        end
      end
      ght_pkg::CMD_REMOVE: begin
        if (cmd_q.handle == '0) begin
          res.status = ght_pkg::ST_BAD_HANDLE;
        end else if (!init_q) begin
          res.status = ght_pkg::ST_NOT_INIT;
        end else if (!idx_ok) begin
          res.status = ght_pkg::ST_BAD_HANDLE;
        end else if (!slot_used || rd_gen != hgen) begin
          res.status = ght_pkg::ST_EXPIRED;
        end else begin
          in_use_d[idx[AddrW-1:0]] = 1'b0;
          if (count_q != '0) count_d = count_q - 1'b1;
        end
      end
      ght_pkg::CMD_INIT: begin
        if (init_q) begin
          res.status = ght_pkg::ST_ALREADY;
        end else begin
          init_d   = 1'b1;
          in_use_d = '0;
          count_d  = '0;
          gen_d    = GenW'(1);
        end
      end
      ght_pkg::CMD_SHUTDOWN: begin
        if (!init_q) begin
          res.status = ght_pkg::ST_NOT_INIT;
        end else begin
          init_d   = 1'b0;
          in_use_d = '0;
          count_d  = '0;
          gen_d    = GenW'(1);
        end
      end
      default: res.status = ght_pkg::ST_BAD_ARG;
    endcase

    res.used_slots = ght_pkg::CntBits'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ght_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      init_q      <= 1'b0;
      in_use_q    <= '0;
      count_q     <= '0;
      gen_q       <= GenW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        init_q   <= init_d;
        in_use_q <= in_use_d;
        count_q  <= count_d;
        gen_q    <= gen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  `GHT_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, state_q == ght_pkg::S_EXEC)
  `GHT_ASSERT_IMP(a_gen_nonzero, clk_i, rst_ni, 1'b1, gen_q != '0)
  `GHT_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(TABLE_ENTRIES))
  `GHT_ASSERT_IMP(a_uninit_empty, clk_i, rst_ni, !init_q, (~|in_use_q) && (count_q == '0))
  `GHT_ASSERT_IMP(a_no_write_idle, clk_i, rst_ni, state_q == ght_pkg::S_IDLE, !fire)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: generational handle table regression
// A directed table covers argument checks, the init/shutdown flag, bad and
// stale handles. It is followed by random traffic built mostly from handles
// the table issued, and a closing insert/remove sweep with no idling. Rows
// without a typed result are checked against a predictor of the slot table.
// ----------------------------------------------------------------------------

module tb;

  localparam int          ENTRIES       = ght_pkg::TableEntriesDef;
  localparam int          RANDOM_ITEMS  = 700;
  localparam int          SWEEP_ROUNDS  = 36;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          CYCLE_LIMIT   = 100000;
  localparam int          STALE_KEEP    = 32;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

  typedef struct {
    ght_pkg::in_t  item;
    bit            typed;
    ght_pkg::out_t want;
  } row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  ght_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  ght_pkg::out_t out_data_o;

  generational_handle_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted table contents
  bit          tbl_on;
  bit          slot_live [ENTRIES];
  logic [15:0] slot_gen  [ENTRIES];
  logic [31:0] slot_ref  [ENTRIES];
  logic [15:0] gen_next;
  int unsigned live_cnt;

  ght_pkg::out_t expected_results [$];
  logic [31:0]   live_handles [$];
  logic [31:0]   stale_handles [$];
  row_t          dir_rows [$];

  bit            throttle = 1'b0;
  int            stall_left = 0;
  int            errors = 0;
  int            cycle_count = 0;
  ght_pkg::out_t mon_want;
  string         mon_bad;

  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i]  = '0;
      slot_ref[i]  = '0;
    end
    gen_next = 16'd1;
    live_cnt = 0;
  endfunction

  function automatic ght_pkg::out_t apply_command(ght_pkg::in_t it);
    ght_pkg::out_t r;
    int            slot;
    int            idx;
    logic [15:0]   hgen;
    r        = '0;
    r.status = ght_pkg::ST_OK;
    slot     = ENTRIES;
    idx      = int'(it.handle[7:0]);
    hgen     = it.handle[31:16];
    case (it.cmd)
      ght_pkg::CMD_INSERT: begin
        if (it.allocation_ref == '0) r.status = ght_pkg::ST_BAD_ARG;
        else if (!tbl_on) r.status = ght_pkg::ST_NOT_INIT;
        else begin
          for (int i = ENTRIES - 1; i >= 0; i--) if (!slot_live[i]) slot = i;
          if (slot == ENTRIES) r.status = ght_pkg::ST_FULL;
          else begin
            slot_live[slot]  = 1'b1;
            slot_gen[slot]   = gen_next;
            slot_ref[slot]   = it.allocation_ref;
            r.handle_out     = {gen_next, it.domain, 8'(slot)};
            r.generation_out = gen_next;
            // zero is never handed out as a generation
            gen_next = (gen_next == 16'hFFFF) ? 16'd1 : gen_next + 16'd1;
            live_cnt++;
          end
        end
      end
      ght_pkg::CMD_LOOKUP: begin
        if (it.handle == '0) r.status = ght_pkg::ST_BAD_ARG;
        else if (!tbl_on) r.status = ght_pkg::ST_NOT_INIT;
        else if (idx >= ENTRIES) r.status = ght_pkg::ST_BAD_HANDLE;
        else if (!slot_live[idx] || slot_gen[idx] != hgen || slot_ref[idx] == '0)
          r.status = ght_pkg::ST_EXPIRED;
        else r.allocation_out = slot_ref[idx];
      end
      ght_pkg::CMD_REMOVE: begin
        if (it.handle == '0) r.status = ght_pkg::ST_BAD_HANDLE;
        else if (!tbl_on) r.status = ght_pkg::ST_NOT_INIT;
        else if (idx >= ENTRIES) r.status = ght_pkg::ST_BAD_HANDLE;
        else if (!slot_live[idx] || slot_gen[idx] != hgen) r.status = ght_pkg::ST_EXPIRED;
        else begin
          slot_live[idx] = 1'b0;
          slot_gen[idx]  = '0;
          slot_ref[idx]  = '0;
          if (live_cnt > 0) live_cnt--;
        end
      end
      ght_pkg::CMD_INIT: begin
        if (tbl_on) r.status = ght_pkg::ST_ALREADY;
        else begin
          wipe_table();
          tbl_on = 1'b1;
        end
      end
      ght_pkg::CMD_SHUTDOWN: begin
        if (!tbl_on) r.status = ght_pkg::ST_NOT_INIT;
        else begin
          wipe_table();
          tbl_on = 1'b0;
        end
      end
      default: r.status = ght_pkg::ST_BAD_ARG;
    endcase
    r.used_slots = 7'(live_cnt);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] cmd, logic [31:0] aref, logic [7:0] dom,
                                  logic [31:0] hnd, bit typed, ght_pkg::status_e st,
                                  logic [31:0] hout, logic [31:0] aout,
                                  logic [15:0] gout, logic [6:0] cnt);
    row_t row;
    row.item                = '{cmd: cmd, allocation_ref: aref, domain: dom, handle: hnd};
    row.typed               = typed;
    row.want                = '0;
    row.want.status         = st;
    row.want.handle_out     = hout;
    row.want.allocation_out = aout;
    row.want.generation_out = gout;
    row.want.used_slots     = cnt;
    dir_rows.push_back(row);
  endfunction

  function automatic ght_pkg::in_t random_command(int ins_pct);
    ght_pkg::in_t it;
    int           pick;
    it.cmd            = ght_pkg::CMD_INIT;
    it.allocation_ref = $urandom;
    if ($urandom_range(0, 19) == 0) it.allocation_ref = '0;
    it.domain = 8'($urandom);
    it.handle = $urandom;
    pick      = $urandom_range(0, 99);
    if (!tbl_on && pick < 60) it.cmd = ght_pkg::CMD_INIT;
    else if (pick < ins_pct) it.cmd = ght_pkg::CMD_INSERT;
    else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) it.cmd = ght_pkg::CMD_LOOKUP;
      else if (pick < 90) it.cmd = ght_pkg::CMD_REMOVE;
      else if (pick < 94) it.cmd = ght_pkg::CMD_INIT;
      else if (pick < 97) it.cmd = ght_pkg::CMD_SHUTDOWN;
      else it.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      pick = $urandom_range(0, 99);
      if (pick < 65 && live_handles.size() > 0) begin
        it.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
        // domain byte is carried but not checked
        if ($urandom_range(0, 3) == 0) it.handle[15:8] = 8'($urandom);
      end else if (pick < 80 && stale_handles.size() > 0) begin
        it.handle = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      end else if (pick < 88) begin
        it.handle = {16'($urandom), 8'($urandom), 8'($urandom_range(0, ENTRIES - 1))};
      end else if (pick < 92) begin
        it.handle = '0;
      end
    end
    return it;
  endfunction

  task automatic send_cmd(input ght_pkg::in_t it, input bit typed, input ght_pkg::out_t want,
                          output ght_pkg::out_t pred);
    if (throttle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_command(it);
    expected_results.push_back(typed ? want : pred);
    // keep the pools of issued and retired handles in step
    if (it.cmd == ght_pkg::CMD_INSERT && pred.status == ght_pkg::ST_OK)
      live_handles.push_back(pred.handle_out);
    if (it.cmd == ght_pkg::CMD_REMOVE && pred.status == ght_pkg::ST_OK) begin
      for (int k = live_handles.size() - 1; k >= 0; k--)
        if (live_handles[k][31:16] == it.handle[31:16] &&
            live_handles[k][7:0] == it.handle[7:0]) begin
          stale_handles.push_back(live_handles[k]);
          live_handles.delete(k);
        end
    end
    if ((it.cmd == ght_pkg::CMD_INIT || it.cmd == ght_pkg::CMD_SHUTDOWN) &&
        pred.status == ght_pkg::ST_OK) begin
      foreach (live_handles[k]) stale_handles.push_back(live_handles[k]);
      live_handles.delete();
    end
    while (stale_handles.size() > STALE_KEEP) void'(stale_handles.pop_front());
  endtask

  // result side: random stall bursts while throttled
  always @(posedge clk_i) begin
    if (throttle && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 7);
      out_ready_i <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", out_data_o);
      end else begin
        mon_want = expected_results.pop_front();
        mon_bad  = "";
        if (out_data_o.status !== mon_want.status) mon_bad = {mon_bad, " status"};
        if (out_data_o.handle_out !== mon_want.handle_out) mon_bad = {mon_bad, " handle_out"};
        if (out_data_o.allocation_out !== mon_want.allocation_out)
          mon_bad = {mon_bad, " allocation_out"};
        if (out_data_o.generation_out !== mon_want.generation_out)
          mon_bad = {mon_bad, " generation_out"};
        if (out_data_o.used_slots !== mon_want.used_slots)
          mon_bad = {mon_bad, " used_slots"};
        if (mon_bad != "") begin
          errors++;
          if (errors <= 10)
            $display("mismatch in%s: expected %p, got %p", mon_bad, mon_want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("generational_handle_table regression: fail");
      $finish;
    end
  end

  initial begin
    ght_pkg::out_t pred;
    ght_pkg::in_t  it;
    int            ins_pct;
    tbl_on = 1'b0;
    wipe_table();

    // argument checks ahead of the init check, then the flag itself
    add_row(ght_pkg::CMD_LOOKUP,   32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_BAD_ARG,    0, 0, 0, 0);
    add_row(ght_pkg::CMD_REMOVE,   32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_BAD_HANDLE, 0, 0, 0, 0);
    add_row(ght_pkg::CMD_INSERT,   32'h0,         8'hFF, 32'h0,         1,
            ght_pkg::ST_BAD_ARG,    0, 0, 0, 0);
    add_row(ght_pkg::CMD_INSERT,   32'h1,         8'h00, 32'h0,         1,
            ght_pkg::ST_NOT_INIT,   0, 0, 0, 0);
    add_row(ght_pkg::CMD_LOOKUP,   32'h0,         8'h00, 32'h0001_0000, 1,
            ght_pkg::ST_NOT_INIT,   0, 0, 0, 0);
    add_row(ght_pkg::CMD_REMOVE,   32'h0,         8'h00, 32'hFFFF_FFFF, 1,
            ght_pkg::ST_NOT_INIT,   0, 0, 0, 0);
    add_row(ght_pkg::CMD_SHUTDOWN, 32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_NOT_INIT,   0, 0, 0, 0);
    add_row(CMD_UNUSED_LO,         32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_BAD_ARG,    0, 0, 0, 0);
    add_row(CMD_UNUSED_HI,         32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1,
            ght_pkg::ST_BAD_ARG,    0, 0, 0, 0);
    add_row(ght_pkg::CMD_INIT,     32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_OK,         0, 0, 0, 0);
    add_row(ght_pkg::CMD_INIT,     32'h0,         8'h00, 32'h0,         1,
            ght_pkg::ST_ALREADY,    0, 0, 0, 0);
    add_row(ght_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'h0, 1,
            ght_pkg::ST_OK, 32'h0001_FF00, 0, 16'd1, 1);
    add_row(ght_pkg::CMD_INSERT, 32'h0000_0001, 8'h00, 32'h0, 1,
            ght_pkg::ST_OK, 32'h0002_0001, 0, 16'd2, 2);
    add_row(ght_pkg::CMD_INSERT, 32'h0, 8'h00, 32'h0, 1, ght_pkg::ST_BAD_ARG, 0, 0, 0, 2);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'h0001_FF00, 1,
            ght_pkg::ST_OK, 0, 32'hFFFF_FFFF, 0, 2);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'h0001_0000, 0, ght_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'h0002_0040, 1,
            ght_pkg::ST_BAD_HANDLE, 0, 0, 0, 2);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'hFFFF_FFFF, 1,
            ght_pkg::ST_BAD_HANDLE, 0, 0, 0, 2);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'h0002_0000, 1,
            ght_pkg::ST_EXPIRED,    0, 0, 0, 2);
    add_row(ght_pkg::CMD_LOOKUP, 32'h0, 8'h00, 32'h0001_0005, 1,
            ght_pkg::ST_EXPIRED,    0, 0, 0, 2);
    add_row(ght_pkg::CMD_REMOVE, 32'h0, 8'h00, 32'h0001_AB00, 1,
            ght_pkg::ST_OK,         0, 0, 0, 1);
    add_row(ght_pkg::CMD_REMOVE, 32'h0, 8'h00, 32'h0001_0000, 1,
            ght_pkg::ST_EXPIRED,    0, 0, 0, 1);
    add_row(ght_pkg::CMD_INSERT, 32'h8000_0000, 8'h5A, 32'h0, 0, ght_pkg::ST_OK, 0, 0, 0, 0);
    add_row(ght_pkg::CMD_REMOVE, 32'h0, 8'h00, 32'h0002_0040, 1,
            ght_pkg::ST_BAD_HANDLE, 0, 0, 0, 2);
    add_row(ght_pkg::CMD_SHUTDOWN, 32'h0, 8'h00, 32'h0, 1, ght_pkg::ST_OK, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni   <= 1'b1;
    @(posedge clk_i);
    throttle <= 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, pred);

    ins_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // each segment picks fill-heavy, balanced or drain-heavy traffic at random
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 20;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        throttle <= ($urandom_range(0, 3) != 0);
      end
      send_cmd(random_command(ins_pct), 1'b0, '0, pred);
    end

    // insert/remove sweep from a fresh table, back to back
    throttle <= 1'b0;
    it = '0;
    if (tbl_on) begin
      it.cmd = ght_pkg::CMD_SHUTDOWN;
      send_cmd(it, 1'b0, '0, pred);
    end
    it.cmd = ght_pkg::CMD_INIT;
    send_cmd(it, 1'b0, '0, pred);
    for (int n = 0; n < SWEEP_ROUNDS; n++) begin
      it                = '0;
      it.cmd            = ght_pkg::CMD_INSERT;
      it.allocation_ref = $urandom_range(1, 32'hFFFF_FFFF);
      it.domain         = 8'($urandom);
      send_cmd(it, 1'b0, '0, pred);
      it.handle = pred.handle_out;
      if (pred.generation_out <= 16'd2) begin
        it.cmd = ght_pkg::CMD_LOOKUP;
        send_cmd(it, 1'b0, '0, pred);
      end
      it.cmd = ght_pkg::CMD_REMOVE;
      send_cmd(it, 1'b0, '0, pred);
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("generational_handle_table regression: pass");
    else $display("generational_handle_table regression: fail");
    $finish;
  end

endmodule

FILE: generational_handle_table.f
+incdir+src
src/ght_pkg.sv
src/ght_ram.sv
src/ght_free_find.sv
src/generational_handle_table.sv
tb/tb.sv
